@@ rtl/core/sensor_orientation_rotate_defines.svh @@
// Assertion macros for the sensor orientation rotation block.
`ifndef SENSOR_ORIENTATION_ROTATE_DEFINES_SVH
`define SENSOR_ORIENTATION_ROTATE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define SOR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("sor: implication failed");

// Next-cycle implication, clocked on clk, off while in reset.
`define SOR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sor: next-cycle implication failed");

`endif

@@ rtl/core/sor_pkg.sv @@
// Shared types, rotation tables and coefficient helpers for the orientation rotator.
`default_nettype none

package sor_pkg;

    localparam int ORIENT_W    = 6;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 1;
    localparam int NUM_CODES   = 44;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ORIENTATION  = 1'b0,
        REG_INVERSE_MODE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic smp_valid;
        logic prod_valid;
    } sor_pipe_t;

    // coefficient selector: sign is negation, magnitude indexes MAG_Q30
    typedef logic signed [4:0] sel_t;

    localparam sel_t K0 = 5'sd0;
    localparam sel_t K1 = 5'sd1;
    localparam sel_t KH = 5'sd2;
    localparam sel_t KS = 5'sd3;
    localparam sel_t KC = 5'sd4;
    localparam sel_t KA = 5'sd5;
    localparam sel_t KB = 5'sd6;
    localparam sel_t KD = 5'sd7;
    localparam sel_t KE = 5'sd8;
    localparam sel_t KF = 5'sd9;
    localparam sel_t KG = 5'sd10;
    localparam sel_t KI = 5'sd11;
    localparam sel_t KJ = 5'sd12;

    localparam logic [31:0] MAG_Q30 [13] = '{
        32'd0,
        32'd1073741824, // 1
        32'd759250125,  // sqrt(2)/2
        32'd130856211,  // sin 7 deg
        32'd1065738315, // cos 7 deg
        32'd153586927,
        32'd395970738,
        32'd986174293,
        32'd356624855,
        32'd919433765,
        32'd424713749,
        32'd1001075059,
        32'd388291426
    };

    // forward matrices, row-major: rows out_x, out_y, out_z; columns x, y, z
    localparam sel_t ROT_TAB [NUM_CODES][9] = '{
        '{ K1,K0,K0,    K0,K1,K0,    K0,K0,K1 },
        '{ KH,-KH,K0,   KH,KH,K0,    K0,K0,K1 },
        '{ K0,-K1,K0,   K1,K0,K0,    K0,K0,K1 },
        '{ -KH,-KH,K0,  KH,-KH,K0,   K0,K0,K1 },
        '{ -K1,K0,K0,   K0,-K1,K0,   K0,K0,K1 },
        '{ -KH,KH,K0,   -KH,-KH,K0,  K0,K0,K1 },
        '{ K0,K1,K0,    -K1,K0,K0,   K0,K0,K1 },
        '{ KH,KH,K0,    -KH,KH,K0,   K0,K0,K1 },
        '{ K1,K0,K0,    K0,-K1,K0,   K0,K0,-K1 },
        '{ KH,KH,K0,    KH,-KH,K0,   K0,K0,-K1 },
        '{ K0,K1,K0,    K1,K0,K0,    K0,K0,-K1 },
        '{ K0,K1,K0,    K1,K0,K0,    K0,K0,-K1 },
        '{ -KH,KH,K0,   KH,KH,K0,    K0,K0,-K1 },
        '{ -K1,K0,K0,   K0,K1,K0,    K0,K0,-K1 },
        '{ -KH,-KH,K0,  -KH,KH,K0,   K0,K0,-K1 },
        '{ K0,-K1,K0,   -K1,K0,K0,   K0,K0,-K1 },
        '{ K0,-K1,K0,   -K1,K0,K0,   K0,K0,-K1 },
        '{ KH,-KH,K0,   -KH,-KH,K0,  K0,K0,-K1 },
        '{ K1,K0,K0,    K0,K0,-K1,   K0,K1,K0 },
        '{ KH,K0,KH,    KH,K0,-KH,   K0,K1,K0 },
        '{ K0,K0,K1,    K1,K0,K0,    K0,K1,K0 },
        '{ -KH,K0,KH,   KH,K0,KH,    K0,K1,K0 },
        '{ K1,K0,K0,    K0,K0,K1,    K0,-K1,K0 },
        '{ KH,K0,-KH,   KH,K0,KH,    K0,-K1,K0 },
        '{ K0,K0,-K1,   K1,K0,K0,    K0,-K1,K0 },
        '{ -KH,K0,-KH,  KH,K0,-KH,   K0,-K1,K0 },
        '{ K0,K0,K1,    K0,K1,K0,    -K1,K0,K0 },
        '{ K0,K0,-K1,   K0,K1,K0,    K1,K0,K0 },
        '{ K0,K1,K0,    K0,K0,-K1,   -K1,K0,K0 },
        '{ K0,K0,-K1,   K0,-K1,K0,   -K1,K0,K0 },
        '{ K0,-K1,K0,   K0,K0,K1,    -K1,K0,K0 },
        '{ -K1,K0,K0,   K0,K0,-K1,   K0,-K1,K0 },
        '{ -K1,K0,K0,   K0,K0,K1,    K0,K1,K0 },
        '{ K0,-K1,K0,   K0,K0,-K1,   K1,K0,K0 },
        '{ K0,K0,K1,    K0,-K1,K0,   K1,K0,K0 },
        '{ K0,K1,K0,    K0,K0,K1,    K1,K0,K0 },
        '{ K0,K0,K1,    -K1,K0,K0,   K0,-K1,K0 },
        '{ K0,K0,-K1,   -K1,K0,K0,   K0,K1,K0 },
        '{ KA,KB,-KD,   -KE,-KF,-KG, -KI,KJ,K0 },
        '{ KH,K0,-KH,   K0,K1,K0,    KH,K0,KH },
        '{ KH,-KH,K0,   K0,K0,-K1,   KH,KH,K0 },
        '{ KC,K0,KS,    K0,K1,K0,    -KS,K0,KC },
        '{ K1,K0,K0,    K0,KH,-KH,   K0,KH,KH },
        '{ K1,K0,K0,    K0,KH,KH,    K0,-KH,KH }
    };

    // Q30 magnitude rounded half up to frac fraction bits
    function automatic logic [31:0] coef_round(input logic [31:0] q30, input int frac);
        logic [31:0] half;
        if (frac >= 30)
        begin
            return q30;
        end
        half = 32'd1 << (29 - frac);
        return (q30 + half) >> (30 - frac);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sor_coef.sv @@
// Coefficient selection: looks up the code's 3x3 matrix, transposed in inverse mode.
`default_nettype none

module sor_coef
    import sor_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 15
)
(
    input  wire logic                             clk,
    input  wire logic [ORIENT_W-1:0]              orientation,
    input  wire logic                             inverse_mode,
    output logic signed [COEF_FRAC_BITS+1:0]      coef [9]
);

    localparam int CW = COEF_FRAC_BITS + 2;

    logic [ORIENT_W-1:0]   code;
    sel_t                  sel [9];
    sel_t                  sel_abs [9];
    logic [31:0]           mag [9];
    logic signed [CW-1:0]  coef_next [9];
    logic signed [CW-1:0]  coef_reg [9];

    always_comb
    begin
        // codes past the table pass through, same as the identity at code 0
        code = (orientation >= ORIENT_W'(NUM_CODES)) ? '0 : orientation;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sel[r*3+c] = inverse_mode ? ROT_TAB[code][c*3+r] : ROT_TAB[code][r*3+c];
                sel_abs[r*3+c] = sel[r*3+c][4] ? -sel[r*3+c] : sel[r*3+c];
                mag[r*3+c] = coef_round(MAG_Q30[sel_abs[r*3+c][3:0]], COEF_FRAC_BITS);
                coef_next[r*3+c] = sel[r*3+c][4] ? -$signed(mag[r*3+c][CW-1:0])
                                                 :  $signed(mag[r*3+c][CW-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule

`default_nettype wire

@@ rtl/core/sor_mac.sv @@
// Sample register, product register and round/saturate result register.
`default_nettype none

module sor_mac
    import sor_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 15
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               accept,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     in_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     in_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     in_z,
    input  wire logic signed [COEF_FRAC_BITS+1:0]   coef [9],
    output logic                                    done,
    output logic signed [SAMPLE_WIDTH-1:0]          out_x,
    output logic signed [SAMPLE_WIDTH-1:0]          out_y,
    output logic signed [SAMPLE_WIDTH-1:0]          out_z,
    output sor_pipe_t                               pipe
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int F    = COEF_FRAC_BITS;
    localparam int PW   = SW + F + 2;
    localparam int SUMW = PW + 2;
    localparam int QW   = SUMW - F;

    localparam logic signed [SUMW-1:0] HALF = {{(SUMW-1){1'b0}}, 1'b1} << (F - 1);
    localparam logic signed [QW-1:0] QMAX = {{(QW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN = {{(QW-SW+1){1'b1}}, {(SW-1){1'b0}}};

    logic signed [SW-1:0]    smp_reg [3];
    logic                    smp_valid_reg;
    logic signed [PW-1:0]    prod_next [9];
    logic signed [PW-1:0]    prod_reg [9];
    logic                    prod_valid_reg;
    logic signed [SUMW-1:0]  sum [3];
    logic signed [SUMW-1:0]  biased [3];
    logic signed [QW-1:0]    quo [3];
    logic signed [SW-1:0]    res_next [3];
    logic signed [SW-1:0]    res_reg [3];
    logic                    done_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_reg[0] <= in_x;
            smp_reg[1] <= in_y;
            smp_reg[2] <= in_z;
        end
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            smp_valid_reg  <= accept;
            prod_valid_reg <= smp_valid_reg;
            done_reg       <= prod_valid_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r*3+c] = PW'(smp_reg[c]) * PW'(coef[r*3+c]);
            end
        end
    end

    // floor((sum + half) / 2^F) rounds to nearest, ties toward plus infinity
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum[r] = SUMW'(prod_reg[r*3]) + SUMW'(prod_reg[r*3+1]) + SUMW'(prod_reg[r*3+2]);
            biased[r] = sum[r] + HALF;
            quo[r] = QW'(biased[r] >>> F);
            if (quo[r] > QMAX)
            begin
                res_next[r] = QMAX[SW-1:0];
            end
            else if (quo[r] < QMIN)
            begin
                res_next[r] = QMIN[SW-1:0];
            end
            else
            begin
                res_next[r] = quo[r][SW-1:0];
            end
        end
    end

    assign done  = done_reg;
    assign out_x = res_reg[0];
    assign out_y = res_reg[1];
    assign out_z = res_reg[2];
    assign pipe.smp_valid  = smp_valid_reg;
    assign pipe.prod_valid = prod_valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/sensor_orientation_rotate.sv @@
// Three-axis sample rotation into the board frame by a configured orientation matrix.
// An accepted beat moves through the sample and product registers into the round/saturate
// register, which drives done and the result beat (out_* valid while done is high).
// Throughput: one beat per cycle; busy is never raised, three-stage pipeline
// (sample register, product register, round/saturate register).
// The receiver cannot stall: each result stands for exactly one cycle.
// Reset (rst_n low, async) clears pipeline valids, orientation and inverse_mode to 0.
`default_nettype none

`include "sensor_orientation_rotate_defines.svh"

module sensor_orientation_rotate
    import sor_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 15
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]           cfg_data,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  in_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  in_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  in_z,
    output logic                                 done,
    output logic signed [SAMPLE_WIDTH-1:0]       out_x,
    output logic signed [SAMPLE_WIDTH-1:0]       out_y,
    output logic signed [SAMPLE_WIDTH-1:0]       out_z
);

    logic [ORIENT_W-1:0]                orientation_reg;
    logic                               inverse_mode_reg;
    logic                               accept;
    logic signed [COEF_FRAC_BITS+1:0]   coef [9];
    sor_pipe_t                          pipe;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg  <= '0;
            inverse_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ORIENTATION:  orientation_reg  <= cfg_data[ORIENT_W-1:0];
                REG_INVERSE_MODE: inverse_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    sor_coef #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_coef (
        .clk          (clk),
        .orientation  (orientation_reg),
        .inverse_mode (inverse_mode_reg),
        .coef         (coef)
    );

    sor_mac #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .in_x   (in_x),
        .in_y   (in_y),
        .in_z   (in_z),
        .coef   (coef),
        .done   (done),
        .out_x  (out_x),
        .out_y  (out_y),
        .out_z  (out_z),
        .pipe   (pipe)
    );

    // every accepted beat enters the pipeline and comes out with done, and nothing else does
    `SOR_ASSERT_NEXT(a_accept_enters, accept, pipe.smp_valid)
    `SOR_ASSERT_IMPL(a_accept_done, accept, ##3 done)
    `SOR_ASSERT_IMPL(a_done_from_accept, done, $past(accept, 3))

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the sensor orientation rotator: directed and random sample beats.
`timescale 1ns / 1ps

module testbench;

    localparam int  NUM_ROTATIONS = 44;
    localparam int  LATENCY       = 3;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  PHASE_BEATS   = 18;
    localparam int  RANDOM_PHASES = 96;
    localparam longint SAMPLE_MAX = 32767;
    localparam longint SAMPLE_MIN = -32768;

    // magnitude selectors; a negative entry negates the magnitude
    localparam int ZR = 0;
    localparam int UN = 1;   // unit
    localparam int RH = 2;   // sqrt(2)/2
    localparam int S7 = 3;   // sin 7 deg
    localparam int C7 = 4;   // cos 7 deg
    localparam int GA = 5;
    localparam int GB = 6;
    localparam int GD = 7;
    localparam int GE = 8;
    localparam int GF = 9;
    localparam int GG = 10;
    localparam int GI = 11;
    localparam int GJ = 12;

    localparam longint MAGNITUDE_Q30 [13] = '{
        0, 1073741824, 759250125, 130856211, 1065738315, 153586927, 395970738,
        986174293, 356624855, 919433765, 424713749, 1001075059, 388291426
    };

    // row-major forward matrices: rows out_x, out_y, out_z; columns x, y, z
    localparam int ROTATION [NUM_ROTATIONS][9] = '{
        '{ UN,ZR,ZR,    ZR,UN,ZR,    ZR,ZR,UN },
        '{ RH,-RH,ZR,   RH,RH,ZR,    ZR,ZR,UN },
        '{ ZR,-UN,ZR,   UN,ZR,ZR,    ZR,ZR,UN },
        '{ -RH,-RH,ZR,  RH,-RH,ZR,   ZR,ZR,UN },
        '{ -UN,ZR,ZR,   ZR,-UN,ZR,   ZR,ZR,UN },
        '{ -RH,RH,ZR,   -RH,-RH,ZR,  ZR,ZR,UN },
        '{ ZR,UN,ZR,    -UN,ZR,ZR,   ZR,ZR,UN },
        '{ RH,RH,ZR,    -RH,RH,ZR,   ZR,ZR,UN },
        '{ UN,ZR,ZR,    ZR,-UN,ZR,   ZR,ZR,-UN },
        '{ RH,RH,ZR,    RH,-RH,ZR,   ZR,ZR,-UN },
        '{ ZR,UN,ZR,    UN,ZR,ZR,    ZR,ZR,-UN },
        '{ ZR,UN,ZR,    UN,ZR,ZR,    ZR,ZR,-UN },
        '{ -RH,RH,ZR,   RH,RH,ZR,    ZR,ZR,-UN },
        '{ -UN,ZR,ZR,   ZR,UN,ZR,    ZR,ZR,-UN },
        '{ -RH,-RH,ZR,  -RH,RH,ZR,   ZR,ZR,-UN },
        '{ ZR,-UN,ZR,   -UN,ZR,ZR,   ZR,ZR,-UN },
        '{ ZR,-UN,ZR,   -UN,ZR,ZR,   ZR,ZR,-UN },
        '{ RH,-RH,ZR,   -RH,-RH,ZR,  ZR,ZR,-UN },
        '{ UN,ZR,ZR,    ZR,ZR,-UN,   ZR,UN,ZR },
        '{ RH,ZR,RH,    RH,ZR,-RH,   ZR,UN,ZR },
        '{ ZR,ZR,UN,    UN,ZR,ZR,    ZR,UN,ZR },
        '{ -RH,ZR,RH,   RH,ZR,RH,    ZR,UN,ZR },
        '{ UN,ZR,ZR,    ZR,ZR,UN,    ZR,-UN,ZR },
        '{ RH,ZR,-RH,   RH,ZR,RH,    ZR,-UN,ZR },
        '{ ZR,ZR,-UN,   UN,ZR,ZR,    ZR,-UN,ZR },
        '{ -RH,ZR,-RH,  RH,ZR,-RH,   ZR,-UN,ZR },
        '{ ZR,ZR,UN,    ZR,UN,ZR,    -UN,ZR,ZR },
        '{ ZR,ZR,-UN,   ZR,UN,ZR,    UN,ZR,ZR },
        '{ ZR,UN,ZR,    ZR,ZR,-UN,   -UN,ZR,ZR },
        '{ ZR,ZR,-UN,   ZR,-UN,ZR,   -UN,ZR,ZR },
        '{ ZR,-UN,ZR,   ZR,ZR,UN,    -UN,ZR,ZR },
        '{ -UN,ZR,ZR,   ZR,ZR,-UN,   ZR,-UN,ZR },
        '{ -UN,ZR,ZR,   ZR,ZR,UN,    ZR,UN,ZR },
        '{ ZR,-UN,ZR,   ZR,ZR,-UN,   UN,ZR,ZR },
        '{ ZR,ZR,UN,    ZR,-UN,ZR,   UN,ZR,ZR },
        '{ ZR,UN,ZR,    ZR,ZR,UN,    UN,ZR,ZR },
        '{ ZR,ZR,UN,    -UN,ZR,ZR,   ZR,-UN,ZR },
        '{ ZR,ZR,-UN,   -UN,ZR,ZR,   ZR,UN,ZR },
        '{ GA,GB,-GD,   -GE,-GF,-GG, -GI,GJ,ZR },
        '{ RH,ZR,-RH,   ZR,UN,ZR,    RH,ZR,RH },
        '{ RH,-RH,ZR,   ZR,ZR,-UN,   RH,RH,ZR },
        '{ C7,ZR,S7,    ZR,UN,ZR,    -S7,ZR,C7 },
        '{ UN,ZR,ZR,    ZR,RH,-RH,   ZR,RH,RH },
        '{ UN,ZR,ZR,    ZR,RH,RH,    ZR,-RH,RH }
    };

    // sender idle percentage per group of three phases; the receiver has no hold-off and is never stalled
    localparam int SENDER_IDLE_PCT [4] = '{0, 55, 0, 34};

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } axes_t;

    class rotation_scoreboard;
        logic [5:0] orientation;
        logic       inverse;
        axes_t      expected_q[$];
        int         mismatches;

        function new();
            orientation = '0;
            inverse     = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_register(sor_pkg::cfg_reg_t idx, logic [5:0] data);
            case (idx)
                sor_pkg::REG_ORIENTATION:  orientation = data;
                sor_pkg::REG_INVERSE_MODE: inverse = data[0];
            endcase
        endfunction

        function axes_t rotate_sample(axes_t s);
            longint v [3];
            longint acc;
            longint coef;
            longint q;
            int     sel;
            int     row;
            int     col;
            axes_t  r;
            if (orientation >= NUM_ROTATIONS)
            begin
                return s;
            end
            v[0] = s.x;
            v[1] = s.y;
            v[2] = s.z;
            for (row = 0; row < 3; row++)
            begin
                acc = 0;
                for (col = 0; col < 3; col++)
                begin
                    sel = inverse ? ROTATION[orientation][col * 3 + row]
                                  : ROTATION[orientation][row * 3 + col];
                    // Q30 magnitude to Q15, half up
                    coef = (MAGNITUDE_Q30[sel < 0 ? -sel : sel] + 64'sd16384) >>> 15;
                    if (sel < 0)
                    begin
                        coef = -coef;
                    end
                    acc += coef * v[col];
                end
                q = (acc + 64'sd16384) >>> 15;
                if (q > SAMPLE_MAX)
                begin
                    q = SAMPLE_MAX;
                end
                else if (q < SAMPLE_MIN)
                begin
                    q = SAMPLE_MIN;
                end
                case (row)
                    0: r.x = q[15:0];
                    1: r.y = q[15:0];
                    default: r.z = q[15:0];
                endcase
            end
            return r;
        endfunction

        function void note_input(axes_t s);
            expected_q.push_back(rotate_sample(s));
        endfunction

        function void check_result(axes_t got);
            axes_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result beat (%0d,%0d,%0d)", got.x, got.y, got.z);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: orient %0d inv %0d expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                             orientation, inverse, want.x, want.y, want.z,
                             got.x, got.y, got.z);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [sor_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [sor_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
    logic                             start = 1'b0;
    logic signed [15:0]               in_x = '0;
    logic signed [15:0]               in_y = '0;
    logic signed [15:0]               in_z = '0;
    logic                             busy;
    logic                             done;
    logic signed [15:0]               out_x;
    logic signed [15:0]               out_y;
    logic signed [15:0]               out_z;

    rotation_scoreboard sb;
    int cycle_count = 0;

    sensor_orientation_rotate #(
        .SAMPLE_WIDTH   (16),
        .COEF_FRAC_BITS (15)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .done      (done),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sensor_orientation_rotate regression: fail");
            $finish;
        end
    end

    // sampled before this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                sb.check_result('{out_x, out_y, out_z});
            end
            if (start && !busy)
            begin
                sb.note_input('{in_x, in_y, in_z});
            end
            if (cfg_we)
            begin
                sb.write_register(sor_pkg::cfg_reg_t'(cfg_index), cfg_data);
            end
        end
    end

    function automatic logic signed [15:0] pick_axis();
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        return 16'($urandom);
    endfunction

    task automatic send_sample(input axes_t s);
        start <= 1'b1;
        in_x  <= s.x;
        in_y  <= s.y;
        in_z  <= s.z;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause_sender(input int pct);
        int n;
        n = 0;
        while (n < 16 && $urandom_range(0, 99) < pct)
        begin
            n++;
        end
        if (n != 0)
        begin
            start <= 1'b0;
            in_x  <= 16'($urandom);
            in_y  <= 16'($urandom);
            in_z  <= 16'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    // drains the pipeline, then writes both registers
    task automatic set_config(input logic [5:0] orient, input logic inv);
        start <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 1) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sor_pkg::REG_ORIENTATION;
        cfg_data  <= orient;
        @(posedge clk);
        cfg_index <= sor_pkg::REG_INVERSE_MODE;
        cfg_data  <= {5'($urandom_range(0, 31)), inv};  // upper bits must be dropped
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_data  <= 6'($urandom);
    endtask

    initial
    begin
        int         p;
        int         pct;
        logic [5:0] orient;
        logic       inv;

        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: identity
        send_sample('{16'sh7fff, 16'sh8000, 16'sh0000});
        send_sample('{16'sh8000, 16'sh7fff, 16'shffff});
        send_sample('{16'sh0000, 16'sh0000, 16'sh0000});
        send_sample('{16'sh0001, 16'shffff, 16'sh7fff});

        // negating the most negative sample saturates
        set_config(6'd4, 1'b0);
        send_sample('{16'sh8000, 16'sh8000, 16'sh8000});
        send_sample('{16'sh7fff, 16'sh7fff, 16'sh7fff});

        // general matrix, both directions
        set_config(6'd38, 1'b0);
        send_sample('{16'sh7fff, 16'sh7fff, 16'sh8000});
        send_sample('{16'sh8000, 16'sh8000, 16'sh7fff});
        send_sample('{16'sd12345, -16'sd2222, 16'sd777});
        set_config(6'd38, 1'b1);
        send_sample('{16'sh7fff, 16'sh7fff, 16'sh8000});
        send_sample('{16'sh8000, 16'sh8000, 16'sh7fff});

        // codes sharing a matrix
        set_config(6'd10, 1'b0);
        send_sample('{16'sh8000, 16'sh7fff, 16'sh8000});
        set_config(6'd11, 1'b0);
        send_sample('{16'sh8000, 16'sh7fff, 16'sh8000});
        set_config(6'd15, 1'b1);
        send_sample('{16'sh8000, 16'sh7fff, 16'sh8000});
        set_config(6'd16, 1'b1);
        send_sample('{16'sh8000, 16'sh7fff, 16'sh8000});

        // pass-through codes
        set_config(6'd44, 1'b0);
        send_sample('{16'sh8000, 16'sh7fff, 16'sh0001});
        set_config(6'd63, 1'b1);
        send_sample('{16'sh8000, 16'sh7fff, 16'sh0001});

        // 45-degree sum overflows
        set_config(6'd1, 1'b1);
        send_sample('{16'sh7fff, 16'sh7fff, 16'sh8000});

        // every code in both directions, then the pass-through range
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 2 * NUM_ROTATIONS)
            begin
                orient = 6'(p / 2);
                inv    = 1'(p % 2);
            end
            else if (p == 2 * NUM_ROTATIONS)
            begin
                orient = 6'd44;
                inv    = 1'b1;
            end
            else if (p == 2 * NUM_ROTATIONS + 1)
            begin
                orient = 6'd63;
                inv    = 1'b0;
            end
            else
            begin
                orient = 6'($urandom_range(44, 63));
                inv    = 1'($urandom_range(0, 1));
            end
            pct = SENDER_IDLE_PCT[(p / 3) % 4];
            set_config(orient, inv);
            repeat (PHASE_BEATS)
            begin
                send_sample('{pick_axis(), pick_axis(), pick_axis()});
                pause_sender(pct);
            end
        end

        start <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 5) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("sensor_orientation_rotate regression: pass");
        end
        else
        begin
            $display("sensor_orientation_rotate regression: fail");
        end
        $finish;
    end

endmodule
